// ===== rtl/qjec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjec_pkg
// Shared widths, register codes and fixed-point helpers for the quintic
// Julia escape counter.
// ----------------------------------------------------------------------------
package qjec_pkg;

  localparam int ITER_LIMIT  = 256;

  localparam int Q_W         = 32;
  localparam int FRAC        = 24;
  localparam int PROD_W      = 2 * Q_W;
  localparam int RND_W       = PROD_W - FRAC;
  localparam int SUM_W       = RND_W + 2;

  localparam int COORD_W     = 10;
  localparam int CEN_W       = 13;
  localparam int DIFF_W      = CEN_W + 1;
  localparam int MAG_W       = CEN_W;
  localparam int INC_W       = 5;
  localparam int OUT_W       = 9;

  localparam int DIV_CONST   = 250;
  localparam int DIV_HALF    = DIV_CONST / 2;
  localparam int DIV_QUOT    = (1 << FRAC) / DIV_CONST;
  localparam int DIV_REM     = (1 << FRAC) % DIV_CONST;
  localparam int DIV_LOG     = $clog2(DIV_CONST);
  localparam int TAIL_W      = MAG_W + DIV_LOG;
  localparam int RECIP_SH    = TAIL_W + DIV_LOG;
  localparam int RECIP       = ((1 << RECIP_SH) + DIV_CONST - 1) / DIV_CONST;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int TPROD_W     = TAIL_W + RECIP_W;
  localparam int TAILQ_W     = TPROD_W - RECIP_SH;
  localparam int DIV_LAT     = 2;
  localparam int DCNT_W      = $clog2(DIV_LAT + 1);

  localparam int CNT_RAW_W   = $clog2(ITER_LIMIT + (1 << INC_W));
  localparam int CNT_W       = (CNT_RAW_W > OUT_W) ? CNT_RAW_W : OUT_W;

  localparam int IN_TDATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = Q_W;

  localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(4) << (2 * FRAC);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_JULIA_RE  = 3'd0,
    REG_JULIA_IM  = 3'd1,
    REG_CENTER_COL = 3'd2,
    REG_CENTER_ROW = 3'd3,
    REG_COUNT_INC = 3'd4
  } cfg_reg_t;

  // product rounded to Q16.24, nearest, ties away from zero
  function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] m;
    mag = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
    m   = (mag + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
    return p[PROD_W-1] ? -$signed(m[RND_W-1:0]) : $signed(m[RND_W-1:0]);
  endfunction

  // clamp to the 32-bit signed range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1])) begin
      return $signed(v[Q_W-1:0]);
    end else if (v[SUM_W-1]) begin
      return $signed({1'b1, {(Q_W-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(Q_W-1){1'b1}}});
    end
  endfunction

endpackage

// ===== rtl/qjec_startdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjec_startdiv
// Start coordinate from a pixel offset: (offset * 2^24 + 125) / 250, split
// into offset * (2^24 / 250) and a small tail divided by reciprocal multiply.
// mag_q, then base and tail, then tail_q are registered; result valid once busy falls.
// ----------------------------------------------------------------------------
module qjec_startdiv import qjec_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] diff,
  output logic                     busy,
  output logic signed [Q_W-1:0]    coord
);

  logic [DCNT_W-1:0]  cnt;
  logic [MAG_W-1:0]   mag_q;
  logic               neg;
  logic [Q_W-1:0]     base;
  logic [TAIL_W-1:0]  tail;
  logic [TAILQ_W-1:0] tail_q;

  logic [MAG_W-1:0]   mag;
  logic [TPROD_W-1:0] tail_prod;
  logic [Q_W-1:0]     qsum;

  assign mag       = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign tail_prod = TPROD_W'(tail) * TPROD_W'(RECIP);
  assign qsum      = base + Q_W'(tail_q);
  assign busy      = cnt != '0;
  assign coord     = neg ? -$signed(qsum) : $signed(qsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DCNT_W'(DIV_LAT);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_q <= mag;
      neg   <= diff[DIFF_W-1];
    end
    base   <= Q_W'(mag_q) * Q_W'(DIV_QUOT);
    tail   <= TAIL_W'(mag_q) * TAIL_W'(DIV_REM) + TAIL_W'(DIV_HALF);
    tail_q <= tail_prod[TPROD_W-1:RECIP_SH];
  end

endmodule

// ===== rtl/qjec_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjec_mul
// Shared 32x32 signed multiplier with registered product and Q16.24 rounding.
// ----------------------------------------------------------------------------
module qjec_mul import qjec_pkg::*; (
  input  logic                      clk,
  input  logic signed [Q_W-1:0]     a,
  input  logic signed [Q_W-1:0]     b,
  output logic signed [PROD_W-1:0]  p,
  output logic signed [RND_W-1:0]   pr
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

  assign pr = round_q(p);

endmodule

// ===== rtl/quintic_julia_escape_count_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_julia_escape_count_top
// Degree-5 Julia escape-time counter: start point from pixel position, then
// z = z^5 + c on one shared multiplier until |z|^2 > 4 or the limit.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata : pixel_col, pixel_row
//   m_       out  m_tvalid/m_tready  m_tdata : escape_count
//   cfg_     in   cfg_wen            cfg_addr, cfg_wdata
//
// Start point: reciprocal divide of the pixel offset by 250.
// Each pass: ten products through the one multiplier.
// Reset clears control and loads the register defaults.
// A stalled result holds in the output register; the next word is taken and
// its result waits in S_FIN.
// ----------------------------------------------------------------------------
module quintic_julia_escape_count_top import qjec_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // pixel_col, pixel_row
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // escape_count
  input  logic                   cfg_wen,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_TEST, S_YY, S_XY, S_X2FIN, S_X2X2, S_Y2Y2, S_X2Y2,
    S_X4FIN, S_X4X, S_Y4Y, S_X4Y, S_Y4X, S_X5FIN, S_ADDC, S_FIN
  } state_t;

  state_t state;

  logic signed [Q_W-1:0]   julia_re;
  logic signed [Q_W-1:0]   julia_im;
  logic signed [CEN_W-1:0] center_col;
  logic signed [CEN_W-1:0] center_row;
  logic [INC_W-1:0]        count_increment;

  logic signed [Q_W-1:0]   x, y, wx, wy;
  logic signed [RND_W-1:0] ra, rb, rc;
  logic [PROD_W-1:0]       esc;
  logic [CNT_W-1:0]        count;

  logic                    accept;
  logic signed [DIFF_W-1:0] diff_col, diff_row;
  logic                    div_busy, div_busy_row;
  logic signed [Q_W-1:0]   start_x, start_y;
  logic signed [Q_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0] prod_rnd;
  logic [PROD_W-1:0]       esc_sum;
  logic [INC_W-1:0]        inc_eff;

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign diff_col = $signed({{(DIFF_W-COORD_W){1'b0}}, s_tdata[COORD_W-1:0]})
                    - DIFF_W'(center_col);
  assign diff_row = $signed({{(DIFF_W-COORD_W){1'b0}}, s_tdata[2*COORD_W-1:COORD_W]})
                    - DIFF_W'(center_row);
  assign esc_sum  = esc + $unsigned(prod);
  assign inc_eff  = (count_increment == '0) ? INC_W'(1) : count_increment;

  qjec_startdiv u_div_col (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .diff  (diff_col),
    .busy  (div_busy),
    .coord (start_x)
  );

  qjec_startdiv u_div_row (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .diff  (diff_row),
    .busy  (div_busy_row),
    .coord (start_y)
  );

  qjec_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod),
    .pr  (prod_rnd)
  );

  always_comb begin
    unique case (state)
      S_TEST:  begin mul_a = x;  mul_b = x;  end
      S_YY:    begin mul_a = y;  mul_b = y;  end
      S_XY:    begin mul_a = x;  mul_b = y;  end
      S_X2X2:  begin mul_a = wx; mul_b = wx; end
      S_Y2Y2:  begin mul_a = wy; mul_b = wy; end
      S_X2Y2:  begin mul_a = wx; mul_b = wy; end
      S_X4X:   begin mul_a = wx; mul_b = x;  end
      S_Y4Y:   begin mul_a = wy; mul_b = y;  end
      S_X4Y:   begin mul_a = wx; mul_b = y;  end
      S_Y4X:   begin mul_a = wy; mul_b = x;  end
      default: begin mul_a = x;  mul_b = y;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      julia_re        <= -32'sd11744051;
      julia_im        <= 32'sd4532365;
      center_col      <= 13'sd512;
      center_row      <= 13'sd512;
      count_increment <= INC_W'(1);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_JULIA_RE:   julia_re        <= $signed(cfg_wdata[Q_W-1:0]);
        REG_JULIA_IM:   julia_im        <= $signed(cfg_wdata[Q_W-1:0]);
        REG_CENTER_COL: center_col      <= $signed(cfg_wdata[CEN_W-1:0]);
        REG_CENTER_ROW: center_row      <= $signed(cfg_wdata[CEN_W-1:0]);
        REG_COUNT_INC:  count_increment <= cfg_wdata[INC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_busy && !div_busy_row) begin
            x     <= start_x;
            y     <= start_y;
            count <= '0;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          state <= (count >= CNT_W'(ITER_LIMIT)) ? S_FIN : S_YY;
        end
        S_YY: begin
          ra    <= prod_rnd;
          esc   <= $unsigned(prod);
          state <= S_XY;
        end
        S_XY: begin
          rb    <= prod_rnd;
          state <= (esc_sum > ESC_BOUND) ? S_FIN : S_X2FIN;
        end
        S_X2FIN, S_X4FIN: begin
          wx    <= sat_q(SUM_W'(ra) - SUM_W'(rb));
          wy    <= sat_q(SUM_W'(prod_rnd) + SUM_W'(prod_rnd));
          state <= (state == S_X2FIN) ? S_X2X2 : S_X4X;
        end
        S_X2X2: state <= S_Y2Y2;
        S_Y2Y2: begin
          ra    <= prod_rnd;
          state <= S_X2Y2;
        end
        S_X2Y2: begin
          rb    <= prod_rnd;
          state <= S_X4FIN;
        end
        S_X4X: state <= S_Y4Y;
        S_Y4Y: begin
          ra    <= prod_rnd;
          state <= S_X4Y;
        end
        S_X4Y: begin
          rb    <= prod_rnd;
          state <= S_Y4X;
        end
        S_Y4X: begin
          rc    <= prod_rnd;
          state <= S_X5FIN;
        end
        S_X5FIN: begin
          wx    <= sat_q(SUM_W'(ra) - SUM_W'(rb));
          wy    <= sat_q(SUM_W'(rc) + SUM_W'(prod_rnd));
          state <= S_ADDC;
        end
        S_ADDC: begin
          x     <= sat_q(SUM_W'(wx) + SUM_W'(julia_re));
          y     <= sat_q(SUM_W'(wy) + SUM_W'(julia_im));
          count <= count + CNT_W'(inc_eff);
          state <= S_TEST;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA_W'(count[OUT_W-1:0]);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/qjec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qjec_checker
// Port-level checks on the escape counter, bound to the top level.
// ----------------------------------------------------------------------------
module qjec_checker import qjec_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken while a word is in work");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_W] == '0)
    else $error("output padding bits set");

endmodule

bind quintic_julia_escape_count_top qjec_checker u_chk (.*);
